@@ sv/medf_pkg.sv @@
`default_nettype none

package medf_pkg;

    localparam int TIME_W      = 31;
    localparam int VALUE_W     = 32;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [TIME_W-1:0]         time_val_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        time_val_t sample_time;
        value_t    sample_value;
        logic      last_sample;
    } in_word_t;

    typedef struct packed {
        time_val_t median_time;
        value_t    median_value;
        logic      series_end;
    } out_word_t;

endpackage

`default_nettype wire

@@ sv/medf_front.sv @@
`default_nettype none

module medf_front #(
    parameter int WINDOW_SIZE = 5
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  medf_pkg::in_word_t                      sample,
    input  logic                                    queue_full,
    output logic                                    push,
    output medf_pkg::value_t [WINDOW_SIZE-1:0]      push_values,
    output medf_pkg::time_val_t                     push_time,
    output logic                                    push_end
);
    import medf_pkg::*;

    localparam int HIST_DEPTH = WINDOW_SIZE - 1;
    localparam int TIME_DEPTH = (WINDOW_SIZE - 1) / 2;
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

    value_t              hist_reg [HIST_DEPTH];
    time_val_t           time_hist_reg [TIME_DEPTH];
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                accept;
    logic                window_full;

    assign sample_stall = queue_full;
    assign accept       = sample_valid && !queue_full;
    assign window_full  = (fill_reg == FILL_W'(HIST_DEPTH));
    assign push         = accept && window_full;
    assign push_time    = time_hist_reg[0];
    assign push_end     = sample.last_sample;

    always_comb
    begin
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            push_values[i] = hist_reg[i];
        end
        push_values[HIST_DEPTH] = sample.sample_value;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            if (sample.last_sample)
            begin
                fill_next = '0;
            end
            else if (!window_full)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // The history is fully rewritten before a window is formed, so it needs no clearing.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < HIST_DEPTH - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[HIST_DEPTH-1] <= sample.sample_value;
            for (int i = 0; i < TIME_DEPTH - 1; i++)
            begin
                time_hist_reg[i] <= time_hist_reg[i+1];
            end
            time_hist_reg[TIME_DEPTH-1] <= sample.sample_time;
        end
    end

endmodule

`default_nettype wire

@@ sv/medf_queue.sv @@
`default_nettype none

module medf_queue #(
    parameter int ENTRY_W = 193
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [ENTRY_W-1:0] push_data,
    output logic               full,
    input  logic               pop,
    output logic [ENTRY_W-1:0] pop_data,
    output logic               empty
);
    import medf_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [ENTRY_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW:0]        count_reg;
    logic [AW:0]        count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/medf_sorter.sv @@
`default_nettype none

module medf_sorter #(
    parameter int WINDOW_SIZE = 5
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    queue_empty,
    input  medf_pkg::value_t [WINDOW_SIZE-1:0]      pop_values,
    input  medf_pkg::time_val_t                     pop_time,
    input  logic                                    pop_end,
    output logic                                    pop,
    output logic                                    median_valid,
    input  logic                                    median_stall,
    output medf_pkg::out_word_t                     median
);
    import medf_pkg::*;

    localparam int N = WINDOW_SIZE;

    logic [N:0]             valid_reg;
    value_t [N-1:0]         stage_vals_reg [N+1];
    time_val_t              stage_time_reg [N+1];
    logic [N:0]             stage_end_reg;
    value_t [N-1:0]         swap_vals [N];
    logic                   advance;

    // The whole pass pipeline freezes while the final word waits at the output.
    assign advance      = !(valid_reg[N] && median_stall);
    assign pop          = advance && !queue_empty;
    assign median_valid = valid_reg[N];

    assign median.median_time  = stage_time_reg[N];
    assign median.median_value = stage_vals_reg[N][N/2];
    assign median.series_end   = stage_end_reg[N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[N-1:0], pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_vals_reg[0] <= pop_values;
            stage_time_reg[0] <= pop_time;
            stage_end_reg[0]  <= pop_end;
            for (int k = 0; k < N; k++)
            begin
                stage_time_reg[k+1] <= stage_time_reg[k];
                stage_end_reg[k+1]  <= stage_end_reg[k];
            end
        end
    end

    // Odd-even transposition: pass k compares neighbor pairs starting at k mod 2.
    for (genvar k = 0; k < N; k++)
    begin : g_pass
        always_comb
        begin
            swap_vals[k] = stage_vals_reg[k];
            for (int j = k % 2; j + 1 < N; j += 2)
            begin
                if ($signed(stage_vals_reg[k][j]) > $signed(stage_vals_reg[k][j+1]))
                begin
                    swap_vals[k][j]   = stage_vals_reg[k][j+1];
                    swap_vals[k][j+1] = stage_vals_reg[k][j];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stage_vals_reg[k+1] <= swap_vals[k];
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/median_of_five_filter.sv @@
// A sample word that completes a window is queued, then popped into the compare-swap pipeline.
// Throughput: one sample word per cycle while the output is not stalled.
// Rate is set by the WINDOW_SIZE-stage compare-swap pipeline and a four-entry window queue before it.
// Reset: rst_n clears the fill count, queue pointers and pipeline valid bits at once.
// A series is cleared after the sample word that carries the last-sample mark.
`default_nettype none

module median_of_five_filter #(
    parameter int WINDOW_SIZE = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  medf_pkg::in_word_t  sample,
    output logic                median_valid,
    input  logic                median_stall,
    output medf_pkg::out_word_t median
);
    import medf_pkg::*;

    localparam int ENTRY_W = WINDOW_SIZE * VALUE_W + TIME_W + 1;

    logic                         push;
    logic                         queue_full;
    value_t [WINDOW_SIZE-1:0]     push_values;
    time_val_t                    push_time;
    logic                         push_end;
    logic [ENTRY_W-1:0]           push_data;
    logic [ENTRY_W-1:0]           pop_data;
    logic                         pop;
    logic                         queue_empty;
    value_t [WINDOW_SIZE-1:0]     pop_values;
    time_val_t                    pop_time;
    logic                         pop_end;

    assign push_data = {push_end, push_time, push_values};
    assign {pop_end, pop_time, pop_values} = pop_data;

    medf_front #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .queue_full   (queue_full),
        .push         (push),
        .push_values  (push_values),
        .push_time    (push_time),
        .push_end     (push_end)
    );

    medf_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    medf_sorter #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_sorter (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .pop_values   (pop_values),
        .pop_time     (pop_time),
        .pop_end      (pop_end),
        .pop          (pop),
        .median_valid (median_valid),
        .median_stall (median_stall),
        .median       (median)
    );

endmodule

`default_nettype wire

@@ sv/medf_checker.sv @@
`default_nettype none

module medf_checker #(
    parameter int WINDOW_SIZE = 5
) (
    input logic                clk,
    input logic                rst_n,
    input logic                sample_valid,
    input logic                sample_stall,
    input medf_pkg::in_word_t  sample,
    input logic                median_valid,
    input logic                median_stall,
    input medf_pkg::out_word_t median
);
    import medf_pkg::*;

    localparam int HIST_DEPTH = WINDOW_SIZE - 1;
    localparam int POS_W      = $clog2(WINDOW_SIZE);
    localparam int PEND_W     = $clog2(QUEUE_DEPTH + WINDOW_SIZE + 2);

    logic [POS_W-1:0]  pos_reg;
    logic [PEND_W-1:0] pending_reg;
    logic              in_acc;
    logic              out_acc;
    logic              makes_result;

    assign in_acc       = sample_valid && !sample_stall;
    assign out_acc      = median_valid && !median_stall;
    assign makes_result = in_acc && (pos_reg == POS_W'(HIST_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                if (sample.last_sample)
                begin
                    pos_reg <= '0;
                end
                else if (pos_reg != POS_W'(HIST_DEPTH))
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (makes_result && !out_acc)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (out_acc && !makes_result)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        median_valid && median_stall |=> median_valid && $stable(median))
        else $error("stalled median word changed or dropped");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        median_valid |-> pending_reg != '0)
        else $error("median word shown with no completed window outstanding");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> pending_reg >= PEND_W'(QUEUE_DEPTH))
        else $error("sample stalled while the queue cannot be full");

    a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !median_valid)
        else $error("median word valid right after reset");

endmodule

bind median_of_five_filter medf_checker #(.WINDOW_SIZE(WINDOW_SIZE)) u_medf_checker (.*);

`default_nettype wire

@@ tb/sv/tb_median_of_five_filter.sv @@
`default_nettype none

module tb_median_of_five_filter;

    import medf_pkg::*;

    localparam int HISTORY_DEPTH = 4;
    localparam int TIME_DEPTH    = 2;
    localparam int TARGET_WORDS  = 1300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 250;
    localparam int HOLD_AFTER    = 400;

    localparam value_t    VALUE_MIN = value_t'(32'h8000_0000);
    localparam value_t    VALUE_MAX = value_t'(32'h7FFF_FFFF);
    localparam time_val_t TIME_MAX  = time_val_t'(31'h7FFF_FFFF);

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      sample_valid = 1'b0;
    logic      sample_stall;
    in_word_t  sample       = '0;
    logic      median_valid;
    logic      median_stall = 1'b0;
    out_word_t median;

    in_word_t  pending_words[$];
    out_word_t expected_medians[$];

    value_t      value_window[HISTORY_DEPTH] = '{default: '0};
    time_val_t   time_window[TIME_DEPTH]     = '{default: '0};
    int unsigned fill_level                  = 0;

    int total_words    = 0;
    int words_sent     = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int stall_phase    = 0;

    median_of_five_filter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .median_valid (median_valid),
        .median_stall (median_stall),
        .median       (median)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    function automatic value_t median_of_five(input value_t vals[5]);
        value_t sorted[5];
        value_t x;
        int     j;
        for (int i = 0; i < 5; i++)
        begin
            x = vals[i];
            j = i;
            while (j > 0 && sorted[j-1] > x)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = x;
        end
        return sorted[2];
    endfunction

    // Advances the sliding window by one accepted word and queues the median it completes.
    task automatic advance_window(input in_word_t w);
        value_t    win[5];
        out_word_t r;
        if (fill_level >= HISTORY_DEPTH)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
                win[i] = value_window[i];
            win[HISTORY_DEPTH] = w.sample_value;
            r.median_time  = time_window[0];
            r.median_value = median_of_five(win);
            r.series_end   = w.last_sample;
            expected_medians.push_back(r);
        end
        for (int i = 0; i + 1 < HISTORY_DEPTH; i++)
            value_window[i] = value_window[i+1];
        value_window[HISTORY_DEPTH-1] = w.sample_value;
        for (int i = 0; i + 1 < TIME_DEPTH; i++)
            time_window[i] = time_window[i+1];
        time_window[TIME_DEPTH-1] = w.sample_time;
        if (fill_level < HISTORY_DEPTH)
            fill_level++;
        if (w.last_sample)
        begin
            value_window = '{default: '0};
            time_window  = '{default: '0};
            fill_level   = 0;
        end
    endtask

    task automatic add_word(input time_val_t t, input value_t v, input logic last);
        in_word_t w;
        w.sample_time  = t;
        w.sample_value = v;
        w.last_sample  = last;
        pending_words.push_back(w);
    endtask

    function automatic value_t pick_value(input int mode);
        case (mode)
            1: return value_t'(int'($urandom_range(16)) - 8);
            2:
            begin
                case ($urandom_range(3))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return value_t'(int'($urandom_range(2)) - 1);
                    default: return value_t'($urandom);
                endcase
            end
            default: return value_t'($urandom);
        endcase
    endfunction

    task automatic add_random_series();
        int        len;
        int        mode;
        int        pick;
        time_val_t t;
        pick = $urandom_range(99);
        if (pick < 12)
            len = $urandom_range(4, 1);
        else if (pick < 95)
            len = $urandom_range(40, 5);
        else
            len = $urandom_range(120, 60);
        mode = $urandom_range(3);
        t = time_val_t'($urandom);
        for (int k = 0; k < len; k++)
        begin
            if (mode == 3)
                t = time_val_t'($urandom);
            else
                t = t + time_val_t'($urandom_range(1000));
            add_word(t, pick_value(mode), k == len - 1);
        end
    endtask

    // Sender: bursts of words separated by random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                advance_window(sample);
                words_sent++;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (gap_left > 0)
                begin
                    sample_valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_words.size() > 0)
                begin
                    sample       <= pending_words.pop_front();
                    sample_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(30, 1);
                        if ($urandom_range(2) == 0)
                            gap_left = 0;
                        else if ($urandom_range(19) == 0)
                            gap_left = $urandom_range(40, 20);
                        else
                            gap_left = $urandom_range(6, 1);
                    end
                    else
                        burst_left--;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // Receiver: cycles through calm and stalling phases, with one long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            stall_phase = (stall_phase + 1) % 200;
            if (hold_left > 0)
            begin
                median_stall <= 1'b1;
                hold_left--;
            end
            else if (!hold_done && words_sent >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                median_stall <= 1'b1;
            end
            else
            begin
                case (stall_phase / 50)
                    0: median_stall <= 1'b0;
                    1: median_stall <= ($urandom_range(1) == 0);
                    2: median_stall <= ($urandom_range(9) == 0);
                    default: median_stall <= ($urandom_range(9) < 8);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && median_valid && !median_stall)
        begin
            if (expected_medians.size() == 0)
                report_error($sformatf("unexpected median word %h", median));
            else
            begin
                want = expected_medians.pop_front();
                if (median.median_time !== want.median_time)
                    report_error($sformatf("median_time got %h want %h",
                                           median.median_time, want.median_time));
                if (median.median_value !== want.median_value)
                    report_error($sformatf("median_value got %h want %h",
                                           median.median_value, want.median_value));
                if (median.series_end !== want.series_end)
                    report_error($sformatf("series_end got %b want %b",
                                           median.series_end, want.series_end));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        // A lone sample that is also the last of its series.
        add_word('0, '0, 1'b1);
        // A series of four ends before any window is full.
        add_word(TIME_MAX, VALUE_MAX, 1'b0);
        add_word('0, VALUE_MIN, 1'b0);
        add_word(time_val_t'(5), value_t'(-1), 1'b0);
        add_word(time_val_t'(6), value_t'(1), 1'b1);
        // Exactly one window, with the value extremes in it.
        add_word('0, VALUE_MAX, 1'b0);
        add_word(time_val_t'(1), VALUE_MIN, 1'b0);
        add_word(time_val_t'(2), '0, 1'b0);
        add_word(time_val_t'(3), value_t'(-1), 1'b0);
        add_word(TIME_MAX, value_t'(1), 1'b1);
        // Repeated values around the median.
        add_word(time_val_t'(100), value_t'(7), 1'b0);
        add_word(time_val_t'(101), value_t'(7), 1'b0);
        add_word(time_val_t'(102), value_t'(7), 1'b0);
        add_word(time_val_t'(103), value_t'(-7), 1'b0);
        add_word(time_val_t'(104), value_t'(7), 1'b0);
        add_word(time_val_t'(105), VALUE_MIN, 1'b0);
        add_word(time_val_t'(106), VALUE_MAX, 1'b1);
        // Times that wrap through the top of their range.
        add_word(TIME_MAX - time_val_t'(2), VALUE_MIN, 1'b0);
        add_word(TIME_MAX - time_val_t'(1), VALUE_MIN, 1'b0);
        add_word(TIME_MAX, VALUE_MAX, 1'b0);
        add_word('0, VALUE_MAX, 1'b0);
        add_word(time_val_t'(1), value_t'(32'h0001_8000), 1'b0);
        add_word(time_val_t'(2), value_t'(32'hFFFE_8000), 1'b0);
        add_word(time_val_t'(3), '0, 1'b0);
        add_word(time_val_t'(4), VALUE_MAX, 1'b1);
        while (pending_words.size() < TARGET_WORDS)
            add_random_series();
        total_words = pending_words.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (words_sent < total_words || expected_medians.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_medians.size() != 0)
            report_error($sformatf("%0d median words never arrived", expected_medians.size()));
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
